@@ sv/pwfm_pkg.sv @@
// Shared types and constants for the peak width unit.
`timescale 1ns / 1ps
`default_nettype none
package pwfm_pkg;
    localparam int MaxPoints = 256;
    localparam int AddrW = $clog2(MaxPoints);
    localparam int CountW = AddrW + 1;
    localparam int MzW = 32;
    localparam int AbW = 24;
    localparam int FracW = 17;
    localparam int DivW = MzW + AbW + 1;
    localparam logic [FracW-1:0] FracOne = 17'd65536;
    localparam logic [FracW-1:0] FracReset = 17'd32768;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_LEFT = 3'd1,
        ST_NO_RIGHT = 3'd2,
        ST_EQUAL = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic [MzW-1:0] mz_value;
        logic [AbW-1:0] abundance;
        logic last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [MzW:0] width;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic signed [DivW-1:0] dividend;
        logic [AbW:0] divisor;
    } div_req_t;
endpackage
`default_nettype wire

@@ sv/peak_width_at_fraction_of_max_unit.sv @@
// Top level: peak point store, crossing search and width computation.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | mz_value, abundance, last_point
//  out     | output    | out_valid/out_ready | width, status
//  cfg     | input     | cfg_valid/cfg_ready | fraction_q16
//
// Points load one per cycle in the load state into the point RAMs (single
// port, registered read). On the last point the sequencer scans left, then
// right, one entry a cycle through the RAM port, then reads four neighbor
// entries and runs up to two 57-step serial divisions.
// Reset clears counters and control; RAM contents need no clearing.
// A result waiting in the output register stalls only the hand-off of the next result.
`timescale 1ns / 1ps
`default_nettype none
module peak_width_at_fraction_of_max_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pwfm_pkg::in_item_t    in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pwfm_pkg::out_item_t        out_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [pwfm_pkg::FracW-1:0] cfg_data
);
    localparam int AW = pwfm_pkg::AddrW;
    localparam int CW = pwfm_pkg::CountW;
    localparam int MW = pwfm_pkg::MzW;
    localparam int BW = pwfm_pkg::AbW;
    localparam int DW = pwfm_pkg::DivW;

    typedef enum logic [3:0] {
        S_LOAD, S_TGT, S_LSCAN, S_RSCAN, S_RD, S_DIV1, S_DIV2, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] max_idx_reg;
    logic [BW-1:0] max_ab_reg;
    logic ovf_reg;
    logic [pwfm_pkg::FracW-1:0] frac_reg;
    logic [BW-1:0] target_reg;
    logic [AW-1:0] scan_reg;
    logic scan_v_reg;
    logic [AW-1:0] left_reg, right_reg;
    logic lfound_reg;
    logic [2:0] rd_reg;
    logic [MW-1:0] mz_r [4];
    logic [BW-1:0] ab_r [4];
    logic [2:0] status_reg;
    logic signed [MW:0] lmz_reg;
    logic signed [MW:0] width_reg;
    logic [1:0] xs_reg;
    pwfm_pkg::out_item_t out_reg;
    logic out_v_reg;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [MW-1:0] mz_q;
    logic [BW-1:0] ab_q;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] lb, rb;
    logic div_done;
    logic signed [DW-1:0] quot;
    pwfm_pkg::div_req_t dreq;
    logic [pwfm_pkg::FracW-1:0] frac_sat;
    logic [BW+pwfm_pkg::FracW-1:0] prod;
    logic [AW-1:0] last_idx;

    assign in_ready = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_item = out_reg;
    assign ram_we = in_valid && in_ready && !count_reg[CW-1];
    assign ram_addr = ram_we ? count_reg[AW-1:0] : rd_addr;
    assign last_idx = AW'(count_reg - CW'(1));
    assign frac_sat = (frac_reg > pwfm_pkg::FracOne) ? pwfm_pkg::FracOne : frac_reg;
    assign prod = max_ab_reg * frac_sat;
    assign lb = (left_reg == '0) ? '0 : left_reg - AW'(1);
    assign rb = (right_reg == last_idx) ? right_reg : right_reg + AW'(1);

    always_comb
    begin
        rd_addr = scan_reg;
        if (state_reg == S_RD)
        begin
            unique case (rd_reg)
                3'd0: rd_addr = lb;
                3'd1: rd_addr = left_reg;
                3'd2: rd_addr = rb;
                default: rd_addr = right_reg;
            endcase
        end
    end

    pwfm_ram #(.WIDTH(MW), .DEPTH(pwfm_pkg::MaxPoints)) u_mz_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_item.mz_value), .rdata(mz_q)
    );
    pwfm_ram #(.WIDTH(BW), .DEPTH(pwfm_pkg::MaxPoints)) u_ab_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_item.abundance), .rdata(ab_q)
    );

    // crossing operands: side 0 left, side 1 right
    logic [1:0] b_i, a_i;
    logic signed [MW+1:0] dmz;
    logic signed [BW+1:0] dnum, dden;
    logic side;
    assign side = (state_reg == S_DIV2);
    assign b_i = side ? 2'd2 : 2'd0;
    assign a_i = side ? 2'd3 : 2'd1;
    assign dnum = $signed({2'b00, target_reg}) - $signed({2'b00, ab_r[b_i]});
    assign dden = $signed({2'b00, ab_r[a_i]}) - $signed({2'b00, ab_r[b_i]});
    assign dmz = $signed({2'b00, mz_r[a_i]}) - $signed({2'b00, mz_r[b_i]});

    // product registered before division
    logic signed [MW+BW+3:0] mul_reg;
    logic [BW:0] den_reg;
    logic den_neg_reg;
    assign dreq.start = (xs_reg == 2'd1);
    assign dreq.dividend = mul_reg[DW-1:0];
    assign dreq.divisor = den_reg;

    logic signed [DW-1:0] qdiv;
    pwfm_div u_div (
        .clk(clk), .rst_n(rst_n),
        .req(dreq),
        .done(div_done), .quotient(qdiv)
    );
    assign quot = den_neg_reg ? -qdiv : qdiv;

    logic signed [MW:0] xmz;
    assign xmz = 33'($signed({1'b0, mz_r[b_i]}) + quot[MW:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            max_idx_reg <= '0;
            max_ab_reg <= '0;
            ovf_reg <= 1'b0;
            frac_reg <= pwfm_pkg::FracReset;
            out_v_reg <= 1'b0;
            xs_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                frac_reg <= cfg_data;
            end
            if (out_v_reg && out_ready && state_reg != S_DONE)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        if (!count_reg[CW-1])
                        begin
                            count_reg <= count_reg + CW'(1);
                            if (in_item.abundance > max_ab_reg)
                            begin
                                max_ab_reg <= in_item.abundance;
                                max_idx_reg <= count_reg[AW-1:0];
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (in_item.last_point)
                        begin
                            state_reg <= S_TGT;
                        end
                    end
                end
                S_TGT:
                begin
                    target_reg <= BW'(prod >> 16);
                    scan_reg <= '0;
                    scan_v_reg <= 1'b0;
                    lfound_reg <= 1'b0;
                    if (ovf_reg)
                    begin
                        status_reg <= pwfm_pkg::ST_OVERFLOW;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        status_reg <= pwfm_pkg::ST_OK;
                        state_reg <= S_LSCAN;
                    end
                end
                S_LSCAN:
                begin
                    // issue scan_reg, examine previous read
                    if (scan_v_reg && ab_q >= target_reg)
                    begin
                        left_reg <= scan_reg - AW'(1);
                        scan_reg <= last_idx;
                        scan_v_reg <= 1'b0;
                        state_reg <= S_RSCAN;
                    end
                    else if (scan_v_reg && (scan_reg - AW'(1)) == max_idx_reg)
                    begin
                        left_reg <= max_idx_reg;
                        scan_reg <= last_idx;
                        scan_v_reg <= 1'b0;
                        state_reg <= S_RSCAN;
                    end
                    else
                    begin
                        scan_v_reg <= 1'b1;
                        scan_reg <= scan_reg + AW'(1);
                    end
                end
                S_RSCAN:
                begin
                    scan_v_reg <= 1'b1;
                    if (scan_v_reg && ab_q >= target_reg)
                    begin
                        right_reg <= scan_reg + AW'(1);
                        rd_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else if (scan_v_reg && (scan_reg + AW'(1)) == max_idx_reg)
                    begin
                        right_reg <= max_idx_reg;
                        rd_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else if (!scan_v_reg && scan_reg == max_idx_reg)
                    begin
                        right_reg <= max_idx_reg;
                        rd_reg <= '0;
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        scan_reg <= scan_reg - AW'(1);
                    end
                end
                S_RD:
                begin
                    rd_reg <= rd_reg + 3'd1;
                    if (rd_reg != 3'd0)
                    begin
                        mz_r[2'(rd_reg - 3'd1)] <= mz_q;
                        ab_r[2'(rd_reg - 3'd1)] <= ab_q;
                    end
                    if (rd_reg == 3'd4)
                    begin
                        xs_reg <= '0;
                        state_reg <= S_DIV1;
                    end
                end
                S_DIV1, S_DIV2:
                begin
                    if (xs_reg == 2'd0)
                    begin
                        if (state_reg == S_DIV1 && left_reg == '0 && ab_r[1] > target_reg)
                        begin
                            status_reg <= pwfm_pkg::ST_NO_LEFT;
                            state_reg <= S_DONE;
                        end
                        else if (state_reg == S_DIV1 && right_reg == last_idx
                                 && ab_r[3] > target_reg)
                        begin
                            status_reg <= pwfm_pkg::ST_NO_RIGHT;
                            state_reg <= S_DONE;
                        end
                        else if (mz_r[a_i] == mz_r[b_i])
                        begin
                            xs_reg <= 2'd3;
                        end
                        else if (ab_r[a_i] == ab_r[b_i])
                        begin
                            status_reg <= pwfm_pkg::ST_EQUAL;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            mul_reg <= (MW+BW+4)'(dnum * dmz);
                            den_reg <= dden[BW+1] ? (BW+1)'(-dden) : dden[BW:0];
                            den_neg_reg <= dden[BW+1];
                            xs_reg <= 2'd1;
                        end
                    end
                    else if (xs_reg == 2'd1)
                    begin
                        xs_reg <= 2'd2;
                    end
                    else if (xs_reg == 2'd3 || div_done)
                    begin
                        xs_reg <= '0;
                        if (state_reg == S_DIV1)
                        begin
                            lmz_reg <= (xs_reg == 2'd3) ? $signed({1'b0, mz_r[1]}) : xmz;
                            state_reg <= S_DIV2;
                        end
                        else
                        begin
                            width_reg <= ((xs_reg == 2'd3)
                                ? $signed({1'b0, mz_r[3]}) : xmz) - lmz_reg;
                            state_reg <= S_DONE;
                        end
                    end
                end
                default:
                begin
                    if (!out_v_reg || out_ready)
                    begin
                        out_v_reg <= 1'b1;
                        out_reg.status <= status_reg;
                        out_reg.width <= (status_reg == pwfm_pkg::ST_OK) ? width_reg : '0;
                        count_reg <= '0;
                        max_idx_reg <= '0;
                        max_ab_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_LOAD) else $error("ready outside load");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(pwfm_pkg::MaxPoints)) else $error("count overrun");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != pwfm_pkg::ST_OK |-> out_item.width == '0)
        else $error("error width");
`endif
endmodule
`default_nettype wire

@@ sv/pwfm_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pwfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ sv/pwfm_div.sv @@
// Restoring divider, signed dividend over positive divisor, quotient truncated.
`timescale 1ns / 1ps
`default_nettype none
module pwfm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire pwfm_pkg::div_req_t            req,
    output logic                               done,
    output logic signed [pwfm_pkg::DivW-1:0]   quotient
);
    localparam int NumW = pwfm_pkg::DivW;
    logic [NumW-1:0] num_reg;
    logic [pwfm_pkg::AbW:0] den_reg;
    logic [pwfm_pkg::AbW+1:0] rem_reg;
    logic [5:0] cnt_reg;
    logic busy_reg;
    logic neg_reg;
    logic [pwfm_pkg::AbW+1:0] trial;
    logic [pwfm_pkg::AbW+1:0] shifted;

    always_comb
    begin
        shifted = {rem_reg[pwfm_pkg::AbW:0], num_reg[NumW-1]};
        trial = shifted - {1'b0, den_reg};
    end

    assign quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= busy_reg && !req.start && (cnt_reg == 6'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'(NumW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.dividend[NumW-1];
            num_reg <= req.dividend[NumW-1] ? NumW'(-req.dividend) : NumW'(req.dividend);
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[pwfm_pkg::AbW+1])
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                num_reg <= {num_reg[NumW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire
